@@ rtl/fwrv_pkg.sv @@
// Shared types and constants for the FIFO with remove-by-value.
`default_nettype none
package fwrv_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned OCC_W  = 5;

  typedef enum logic [1:0] {
    OP_ENQ    = 2'd0,
    OP_DEQ    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_EMPTY     = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_FULL      = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DEQ,
    ST_SCAN,
    ST_SHIFT,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

@@ rtl/fwrv_if.sv @@
// Request and response channel interfaces for the FIFO with remove-by-value.
`default_nettype none
interface fwrv_req_if;
  logic                               valid;
  logic                               ready;
  fwrv_pkg::op_t                      op;
  logic signed [fwrv_pkg::DATA_W-1:0] value;

  modport source (output valid, op, value, input ready);
  modport sink (input valid, op, value, output ready);
endinterface

interface fwrv_rsp_if;
  logic                               valid;
  logic                               ready;
  logic signed [fwrv_pkg::DATA_W-1:0] result_value;
  fwrv_pkg::status_t                  status;
  logic                               is_empty;
  logic [fwrv_pkg::OCC_W-1:0]         occupancy;

  modport source (output valid, result_value, status, is_empty, occupancy, input ready);
  modport sink (input valid, result_value, status, is_empty, occupancy, output ready);
endinterface
`default_nettype wire

@@ rtl/fifo_with_remove_by_value_unit.sv @@
// Enqueue and unused ops go from the request to the result state; dequeue first waits for
// the head entry from the store; remove reads one entry per cycle from the entry store,
// then the compaction streams behind the scan through the same read port.
// One item is in flight at a time; a waiting result does not block the next input.
// Reset empties the queue; stored entries are left as they are and never read unwritten.
`default_nettype none
module fifo_with_remove_by_value_unit #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input wire logic  clk,
  input wire logic  rst,
  fwrv_req_if.sink  req,
  fwrv_rsp_if.source rsp
);

  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  // Map a position counted from the head to a physical address.
  function automatic logic [AW-1:0] wrap(input logic [AW-1:0] base, input logic [CW-1:0] pos);
    logic [AW:0] s;
    s = {1'b0, base} + (AW+1)'(pos);
    if (s >= (AW+1)'(QUEUE_DEPTH)) begin
      s = s - (AW+1)'(QUEUE_DEPTH);
    end
    return s[AW-1:0];
  endfunction

  fwrv_pkg::state_t state, state_next;
  logic [CW-1:0] count, count_next;
  logic [AW-1:0] head, head_next;
  logic [CW-1:0] rd_pos, rd_pos_next;
  logic [CW-1:0] pend_pos, pend_pos_next;
  logic          pend, pend_next;
  logic [fwrv_pkg::DATA_W-1:0] key, key_next;
  logic [fwrv_pkg::DATA_W-1:0] res_value, res_value_next;
  fwrv_pkg::status_t           res_status, res_status_next;

  logic                          out_valid, out_valid_next;
  logic [fwrv_pkg::DATA_W-1:0]   out_value, out_value_next;
  fwrv_pkg::status_t             out_status, out_status_next;
  logic                          out_empty, out_empty_next;
  logic [fwrv_pkg::OCC_W-1:0]    out_occ, out_occ_next;

  logic                          we;
  logic [AW-1:0]                 waddr;
  logic [fwrv_pkg::DATA_W-1:0]   wdata;
  logic [AW-1:0]                 raddr;
  logic [fwrv_pkg::DATA_W-1:0]   rd_data;
  logic                          issue;

  fwrv_ram #(
    .DEPTH (QUEUE_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rd_data)
  );

  assign req.ready        = (state == fwrv_pkg::ST_IDLE);
  assign rsp.valid        = out_valid;
  assign rsp.result_value = out_value;
  assign rsp.status       = out_status;
  assign rsp.is_empty     = out_empty;
  assign rsp.occupancy    = out_occ;

  // Sequencer: next state, store accesses and result fields.
  always_comb begin
    state_next      = state;
    count_next      = count;
    head_next       = head;
    rd_pos_next     = rd_pos;
    pend_next       = pend;
    pend_pos_next   = pend_pos;
    key_next        = key;
    res_value_next  = res_value;
    res_status_next = res_status;
    out_valid_next  = out_valid & ~rsp.ready;
    out_value_next  = out_value;
    out_status_next = out_status;
    out_empty_next  = out_empty;
    out_occ_next    = out_occ;
    we              = 1'b0;
    waddr           = wrap(head, count);
    wdata           = req.value;
    raddr           = wrap(head, rd_pos);
    issue           = rd_pos < count;

    case (state)
      fwrv_pkg::ST_IDLE: begin
        if (req.valid) begin
          key_next        = req.value;
          res_value_next  = '0;
          res_status_next = fwrv_pkg::STAT_OK;
          rd_pos_next     = '0;
          pend_next       = 1'b0;
          state_next      = fwrv_pkg::ST_DONE;
          case (req.op)
            fwrv_pkg::OP_ENQ: begin
              if (count == CW'(QUEUE_DEPTH)) begin
                res_status_next = fwrv_pkg::STAT_FULL;
              end else begin
                we         = 1'b1;
                count_next = count + CW'(1);
              end
            end
            fwrv_pkg::OP_DEQ: begin
              raddr = head;
              if (count == '0) begin
                res_status_next = fwrv_pkg::STAT_EMPTY;
              end else begin
                state_next = fwrv_pkg::ST_DEQ;
              end
            end
            fwrv_pkg::OP_REMOVE: begin
              state_next = fwrv_pkg::ST_SCAN;
            end
            default: begin
              state_next = fwrv_pkg::ST_DONE;
            end
          endcase
        end
      end

      // Head data is back from the store.
      fwrv_pkg::ST_DEQ: begin
        res_value_next = rd_data;
        head_next      = wrap(head, CW'(1));
        count_next     = count - CW'(1);
        state_next     = fwrv_pkg::ST_DONE;
      end

      // Read one entry per cycle and compare the one read the cycle before.
      fwrv_pkg::ST_SCAN: begin
        pend_next = issue;
        if (issue) begin
          pend_pos_next = rd_pos;
          rd_pos_next   = rd_pos + CW'(1);
        end
        if (pend && (rd_data == key)) begin
          state_next = fwrv_pkg::ST_SHIFT;
        end else if (!issue) begin
          res_status_next = fwrv_pkg::STAT_NOT_FOUND;
          state_next      = fwrv_pkg::ST_DONE;
        end
      end

      // Move each later entry up by one; the write trails the read by two positions.
      fwrv_pkg::ST_SHIFT: begin
        if (pend) begin
          we    = 1'b1;
          waddr = wrap(head, pend_pos - CW'(1));
          wdata = rd_data;
        end
        pend_next = issue;
        if (issue) begin
          pend_pos_next = rd_pos;
          rd_pos_next   = rd_pos + CW'(1);
        end else begin
          count_next = count - CW'(1);
          state_next = fwrv_pkg::ST_DONE;
        end
      end

      // Hand the result to the output register once it is free.
      fwrv_pkg::ST_DONE: begin
        if (!out_valid || rsp.ready) begin
          out_valid_next  = 1'b1;
          out_value_next  = res_value;
          out_status_next = res_status;
          out_empty_next  = (count == '0);
          out_occ_next    = fwrv_pkg::OCC_W'(count);
          state_next      = fwrv_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = fwrv_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= fwrv_pkg::ST_IDLE;
      count     <= '0;
      head      <= '0;
      rd_pos    <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      head      <= head_next;
      rd_pos    <= rd_pos_next;
      pend      <= pend_next;
      out_valid <= out_valid_next;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    pend_pos   <= pend_pos_next;
    key        <= key_next;
    res_value  <= res_value_next;
    res_status <= res_status_next;
    out_value  <= out_value_next;
    out_status <= out_status_next;
    out_empty  <= out_empty_next;
    out_occ    <= out_occ_next;
  end

endmodule
`default_nettype wire

@@ rtl/fwrv_ram.sv @@
// Entry store: one write port and one read port with registered read data.
`default_nettype none
module fwrv_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  wire logic                          clk,
  input  wire logic                          we,
  input  wire logic [AW-1:0]                 waddr,
  input  wire logic [fwrv_pkg::DATA_W-1:0]   wdata,
  input  wire logic [AW-1:0]                 raddr,
  output      logic [fwrv_pkg::DATA_W-1:0]   rdata
);

  logic [fwrv_pkg::DATA_W-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port with registered read data.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ dv/tb_fifo_with_remove_by_value_unit.sv @@
// Self-checking testbench for the FIFO with remove-by-value: directed and random traffic.
`timescale 1ns / 1ps
module tb_fifo_with_remove_by_value_unit;

  localparam int unsigned DEPTH = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 1850;
  localparam int CALM_ITEMS = 250;
  localparam int DRAIN_CYCLES = 40;
  localparam int REPORT_MAX = 10;

  typedef logic signed [fwrv_pkg::DATA_W-1:0] word_t;

  typedef struct {
    word_t                      result_value;
    fwrv_pkg::status_t          status;
    logic                       is_empty;
    logic [fwrv_pkg::OCC_W-1:0] occupancy;
  } rsp_fields_t;

  // Tracks the queue contents and the responses still owed by the block.
  class fifo_scoreboard;
    word_t       queue_model[$];
    rsp_fields_t expected_rsp[$];
    int          fail_count;
    int          report_count;

    function new();
      fail_count = 0;
      report_count = 0;
    endfunction

    function void flag(string what);
      fail_count++;
      if (report_count < REPORT_MAX) begin
        report_count++;
        $display("[%0t] %s", $realtime, what);
      end
    endfunction

    // Apply one accepted request to the model and queue up its response.
    function void note_request(fwrv_pkg::op_t op, word_t val);
      rsp_fields_t outcome;
      int hit;
      outcome.result_value = '0;
      outcome.status = fwrv_pkg::STAT_OK;
      case (op)
        fwrv_pkg::OP_ENQ: begin
          if (queue_model.size() >= DEPTH) outcome.status = fwrv_pkg::STAT_FULL;
          else queue_model.push_back(val);
        end
        fwrv_pkg::OP_DEQ: begin
          if (queue_model.size() == 0) outcome.status = fwrv_pkg::STAT_EMPTY;
          else outcome.result_value = queue_model.pop_front();
        end
        fwrv_pkg::OP_REMOVE: begin
          hit = -1;
          for (int i = 0; i < queue_model.size() && hit < 0; i++) begin
            if (queue_model[i] == val) hit = i;
          end
          if (hit < 0) outcome.status = fwrv_pkg::STAT_NOT_FOUND;
          else queue_model.delete(hit);
        end
        default: ;
      endcase
      outcome.occupancy = fwrv_pkg::OCC_W'(queue_model.size());
      outcome.is_empty = (queue_model.size() == 0);
      expected_rsp.push_back(outcome);
    endfunction

    // Compare one response transfer against the oldest outstanding one.
    function void check_response(word_t rv, fwrv_pkg::status_t st, logic emp,
                                 logic [fwrv_pkg::OCC_W-1:0] occ);
      rsp_fields_t want;
      if (expected_rsp.size() == 0) begin
        flag($sformatf("unexpected response: value=%0d status=%s empty=%0b occupancy=%0d",
                       rv, st.name(), emp, occ));
        return;
      end
      want = expected_rsp.pop_front();
      if (rv !== want.result_value || st !== want.status ||
          emp !== want.is_empty || occ !== want.occupancy) begin
        flag($sformatf({"response mismatch: expected value=%0d status=%s empty=%0b ",
                        "occupancy=%0d, got value=%0d status=%s empty=%0b occupancy=%0d"},
                       want.result_value, want.status.name(), want.is_empty,
                       want.occupancy, rv, st.name(), emp, occ));
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic quiet;
  int   cycles = 0;
  int   rsp_stall_left = 0;

  fwrv_req_if req_ch ();
  fwrv_rsp_if rsp_ch ();

  fifo_scoreboard sb = new();

  fifo_with_remove_by_value_unit #(
    .QUEUE_DEPTH(DEPTH)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  always #2 clk = ~clk;

  // Give up if the run hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Response side back-pressure in short random bursts.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      rsp_stall_left <= 0;
    end else if (quiet) begin
      rsp_ch.ready <= 1'b1;
      rsp_stall_left <= 0;
    end else if (rsp_stall_left > 0) begin
      rsp_ch.ready <= 1'b0;
      rsp_stall_left <= rsp_stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      rsp_ch.ready <= 1'b0;
      rsp_stall_left <= $urandom_range(0, 3);
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  // Check every response transfer.
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      sb.check_response(rsp_ch.result_value, rsp_ch.status, rsp_ch.is_empty,
                        rsp_ch.occupancy);
    end
  end

  // Random data word: small values for duplicates, the extremes, or anything.
  function automatic word_t pick_word();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return word_t'($urandom_range(0, 7));
      4: begin
        case ($urandom_range(0, 3))
          0: return 32'sh8000_0000;
          1: return 32'sh7FFF_FFFF;
          2: return '0;
          default: return '1;
        endcase
      end
      default: return word_t'($urandom);
    endcase
  endfunction

  // Present one request and hold it until the transfer happens.
  task automatic send_item(input fwrv_pkg::op_t op, input word_t val);
    int gap;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 4);
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.op <= op;
    req_ch.value <= val;
    do @(posedge clk); while (!req_ch.ready);
    sb.note_request(op, val);
  endtask

  // Stop sending until every outstanding response has arrived.
  task automatic hold_until_drained();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.expected_rsp.size() != 0);
  endtask

  initial begin
    int            counted;
    int            mode;
    int            roll;
    int            enq_cut;
    int            deq_cut;
    fwrv_pkg::op_t op;
    word_t         val;

    rst <= 1'b1;
    quiet <= 1'b0;
    req_ch.valid <= 1'b0;
    req_ch.op <= fwrv_pkg::OP_NONE;
    req_ch.value <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty-queue cases, the unused op, extremes, tail and head removal.
    send_item(fwrv_pkg::OP_DEQ, 32'sd5);
    send_item(fwrv_pkg::OP_REMOVE, '0);
    send_item(fwrv_pkg::OP_NONE, 32'sh7FFF_FFFF);
    send_item(fwrv_pkg::OP_ENQ, 32'sh8000_0000);
    send_item(fwrv_pkg::OP_ENQ, 32'sh7FFF_FFFF);
    send_item(fwrv_pkg::OP_ENQ, '1);
    send_item(fwrv_pkg::OP_REMOVE, '1);
    send_item(fwrv_pkg::OP_REMOVE, 32'sd12345);
    send_item(fwrv_pkg::OP_REMOVE, 32'sh8000_0000);
    // Fill to the brim with duplicates, then push once more and pop.
    for (int i = 0; i < DEPTH - 1; i++) send_item(fwrv_pkg::OP_ENQ, word_t'(i % 4));
    send_item(fwrv_pkg::OP_ENQ, 32'sd99);
    send_item(fwrv_pkg::OP_DEQ, '0);
    hold_until_drained();

    // Random traffic in phases that lean toward filling, draining or neither.
    counted = 0;
    mode = 0;
    while (counted < RANDOM_ITEMS) begin
      if (counted % 150 == 0) mode = $urandom_range(0, 2);
      quiet <= (counted >= RANDOM_ITEMS - CALM_ITEMS);
      if (counted == 700 || counted == 1300) hold_until_drained();
      if ($urandom_range(0, 99) < 3) begin
        send_item(fwrv_pkg::OP_NONE, pick_word());
        counted++;
        continue;
      end
      case (mode)
        1: begin enq_cut = 65; deq_cut = 75; end
        2: begin enq_cut = 25; deq_cut = 70; end
        default: begin enq_cut = 40; deq_cut = 70; end
      endcase
      roll = $urandom_range(0, 99);
      if (roll < enq_cut) begin
        op = fwrv_pkg::OP_ENQ;
        val = pick_word();
      end else if (roll < deq_cut) begin
        op = fwrv_pkg::OP_DEQ;
        val = word_t'($urandom);
      end else begin
        op = fwrv_pkg::OP_REMOVE;
        if (sb.queue_model.size() != 0 && $urandom_range(0, 3) != 0)
          val = sb.queue_model[$urandom_range(0, sb.queue_model.size() - 1)];
        else
          val = pick_word();
      end
      send_item(op, val);
      counted++;
    end

    // Let the last responses come back, then give the verdict.
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.expected_rsp.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
